>>> sv/tlca_pkg.sv
// tlca_pkg: shared types and constants for the tree lowest common ancestor block
// used by tlca_step, tlca_table and tree_lowest_common_ancestor; no dependencies
package tlca_pkg;

    localparam int TLCA_MAX_NODES = 65536;
    localparam int NODE_W         = 16;
    localparam int LIMIT_W        = 25;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_LCA  = 2'd1;
    localparam logic [1:0] OP_ANC  = 2'd2;

    typedef logic [NODE_W-1:0] t_node;

    typedef struct packed {
        logic [1:0] operation;
        t_node      node_a;
        t_node      node_b;
        t_node      entry_index;
        t_node      entry_parent;
    } t_cmd;

    typedef struct packed {
        t_node ancestor_node;
        logic  is_ancestor;
        logic  malformed;
    } t_res;

    typedef struct packed {
        logic  done;
        logic  hi_is_a;
        t_node hi;
        logic  same;
        logic  bad;
    } t_step;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_STEP
    } t_state;

endpackage

>>> sv/tlca_step.sv
// tlca_step: shared compare unit for one walk step
// picks the node to climb, tests for the end of the walk and checks the parent; uses tlca_pkg
module tlca_step (
    input  logic [1:0]     i_op,
    input  tlca_pkg::t_node i_a,
    input  tlca_pkg::t_node i_b,
    input  tlca_pkg::t_node i_parent,
    output tlca_pkg::t_step o_step
);
    import tlca_pkg::*;

    logic  hi_is_a;
    t_node hi;

    always_comb begin
        hi_is_a = (i_op == OP_LCA) ? (i_a > i_b) : 1'b0;
        hi      = hi_is_a ? i_a : i_b;
    end

    always_comb begin
        o_step.hi_is_a = hi_is_a;
        o_step.hi      = hi;
        o_step.same    = (i_a == i_b);
        o_step.done    = (i_op == OP_LCA) ? (i_a == i_b) : (i_b <= i_a);
        o_step.bad     = (i_parent >= hi);
    end

endmodule

>>> sv/tlca_table.sv
// tlca_table: parent table memory, one write port and one registered read port
// uses tlca_pkg for the node type
module tlca_table #(
    parameter int DEPTH = tlca_pkg::TLCA_MAX_NODES,
    parameter int AW    = tlca_pkg::NODE_W
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  tlca_pkg::t_node i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output tlca_pkg::t_node o_rdata
);
    import tlca_pkg::*;

    t_node r_mem [DEPTH];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/tree_lowest_common_ancestor.sv
// tree_lowest_common_ancestor: parent table with lowest common ancestor and ancestor queries
// depends on tlca_pkg, tlca_step and tlca_table
//
// a command beat is taken at a rising edge with start high and busy low
// a load writes one table entry in that cycle; busy stays low and no result follows
// a query raises busy and walks parent pointers, one table read per step:
//   each step is a table read state, then a compare state in the shared step unit
//   the result strobe o_res_valid is high for one cycle; it is registered when the
//   read state finds the walk done, or when a compare finds a parent not below its
//   child; a query with a zero node answers in the next cycle
// busy drops as the result is registered, so a new command may follow at once
// an unknown operation code is dropped without a result
// the receiver cannot stall: each result beat is shown for exactly one cycle
// reset clears the sequencer and the strobe; table contents stay undefined until loaded
// entries at or above MAX_NODES are never stored and read as parent 0
module tree_lowest_common_ancestor #(
    parameter int MAX_NODES = tlca_pkg::TLCA_MAX_NODES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tlca_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    output tlca_pkg::t_res o_res
);
    import tlca_pkg::*;

    localparam int DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LIMIT_W-1:0] LIMIT = LIMIT_W'(MAX_NODES);

    t_state r_state, n_state;
    logic [1:0] r_op, n_op;
    t_node r_a, n_a;
    t_node r_b, n_b;
    logic  r_oor, n_oor;
    logic  r_res_valid, n_res_valid;
    t_res  r_res, n_res;

    logic    accept;
    logic    zero_op;
    logic    we;
    logic    re;
    t_node   rdata;
    t_node   parent;
    t_step   step;

    assign accept  = start && (r_state == S_IDLE);
    assign zero_op = (i_cmd.node_a == '0) || (i_cmd.node_b == '0);
    assign parent  = r_oor ? '0 : rdata;
    assign we      = accept && (i_cmd.operation == OP_LOAD)
                     && ({{(LIMIT_W-NODE_W){1'b0}}, i_cmd.entry_index} < LIMIT);
    assign re      = (r_state == S_READ) && !step.done;

    tlca_step u_step (
        .i_op     (r_op),
        .i_a      (r_a),
        .i_b      (r_b),
        .i_parent (parent),
        .o_step   (step)
    );

    tlca_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_cmd.entry_index[AW-1:0]),
        .i_wdata (i_cmd.entry_parent),
        .i_re    (re),
        .i_raddr (step.hi[AW-1:0]),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !zero_op
                    && (i_cmd.operation == OP_LCA || i_cmd.operation == OP_ANC)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = step.done ? S_IDLE : S_STEP;
            end
            S_STEP: begin
                n_state = step.bad ? S_IDLE : S_READ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_oor       = r_oor;
        n_res_valid = 1'b0;
        n_res       = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = i_cmd.operation;
                    n_a  = i_cmd.node_a;
                    n_b  = i_cmd.node_b;
                    if (zero_op && i_cmd.operation == OP_LCA) begin
                        n_res_valid         = 1'b1;
                        n_res.ancestor_node = (i_cmd.node_a != '0) ? i_cmd.node_a
                                                                   : i_cmd.node_b;
                        n_res.is_ancestor   = 1'b0;
                        n_res.malformed     = 1'b0;
                    end else if (zero_op && i_cmd.operation == OP_ANC) begin
                        n_res_valid         = 1'b1;
                        n_res.ancestor_node = '0;
                        n_res.is_ancestor   = 1'b0;
                        n_res.malformed     = 1'b0;
                    end
                end
            end
            S_READ: begin
                n_oor = ({{(LIMIT_W-NODE_W){1'b0}}, step.hi} >= LIMIT);
                if (step.done) begin
                    n_res_valid = 1'b1;
                    n_res.malformed = 1'b0;
                    if (r_op == OP_LCA) begin
                        n_res.ancestor_node = r_a;
                        n_res.is_ancestor   = 1'b0;
                    end else begin
                        n_res.ancestor_node = '0;
                        n_res.is_ancestor   = step.same;
                    end
                end
            end
            S_STEP: begin
                if (step.bad) begin
                    n_res_valid         = 1'b1;
                    n_res.ancestor_node = '0;
                    n_res.is_ancestor   = 1'b0;
                    n_res.malformed     = 1'b1;
                end else if (step.hi_is_a) begin
                    n_a = parent;
                end else begin
                    n_b = parent;
                end
            end
            default: n_res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_oor <= n_oor;
        r_res <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> dv/tb_tree_lowest_common_ancestor.sv
// tb_tree_lowest_common_ancestor: self-checking bench for the parent table lca block
// plans load, lca, ancestor and unknown-op commands on a growing forest and checks every result beat
// depends on tlca_pkg and tree_lowest_common_ancestor
module tb_tree_lowest_common_ancestor;
    import tlca_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int IDLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 600;
    localparam int TOP_NODE     = 65535;

    typedef struct packed {
        t_cmd cmd;
        int   gap;
    } t_slot;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_cmd i_cmd = '0;
    logic o_res_valid;
    t_res o_res;

    t_slot cmd_q[$];
    t_res  answer_q[$];
    t_res  next_answer;
    t_res  want;
    bit [NODE_W-1:0] tree_parent [TLCA_MAX_NODES];
    bit [NODE_W-1:0] plan_parent [TLCA_MAX_NODES];
    bit              plan_known  [TLCA_MAX_NODES];
    int plan_nodes[$];
    int fails = 0;
    int idle_cycles = 0;

    tree_lowest_common_ancestor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fails++;
    endtask

    function automatic int unsigned parent_of(input int unsigned n);
        if (n < TLCA_MAX_NODES) return 32'(tree_parent[n]);
        return 0;
    endfunction

    function automatic bit predict_answer(input t_cmd c, output t_res r);
        int unsigned a;
        int unsigned b;
        int unsigned p;
        bit bad;
        a = 32'(c.node_a);
        b = 32'(c.node_b);
        bad = 1'b0;
        r = '0;
        case (c.operation)
            OP_LOAD: begin
                if (c.entry_index < TLCA_MAX_NODES) tree_parent[c.entry_index] = c.entry_parent;
                return 1'b0;
            end
            OP_LCA: begin
                if (a == 0 || b == 0) begin
                    r.ancestor_node = (a != 0) ? t_node'(a) : t_node'(b);
                end else begin
                    while (a != b && !bad) begin
                        if (a > b) begin
                            p = parent_of(a);
                            if (p >= a) bad = 1'b1;
                            else a = p;
                        end else begin
                            p = parent_of(b);
                            if (p >= b) bad = 1'b1;
                            else b = p;
                        end
                    end
                    r.ancestor_node = bad ? '0 : t_node'(a);
                    r.malformed = bad;
                end
                return 1'b1;
            end
            OP_ANC: begin
                if (a != 0 && b != 0) begin
                    while (b > a && !bad) begin
                        p = parent_of(b);
                        if (p >= b) bad = 1'b1;
                        else b = p;
                    end
                    r.is_ancestor = !bad && b == a;
                    r.malformed = bad;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // fields a command does not use get random content
    task automatic plan_cmd(input logic [1:0] op, input int a, input int b,
                            input int idx, input int par);
        t_slot s;
        s = '0;
        s.cmd.operation = op;
        if (op == OP_LOAD) begin
            s.cmd.node_a = t_node'($urandom);
            s.cmd.node_b = t_node'($urandom);
            s.cmd.entry_index = t_node'(idx);
            s.cmd.entry_parent = t_node'(par);
            if (!plan_known[idx]) plan_nodes.push_back(idx);
            plan_known[idx] = 1'b1;
            plan_parent[idx] = t_node'(par);
        end else begin
            s.cmd.node_a = t_node'(a);
            s.cmd.node_b = t_node'(b);
            s.cmd.entry_index = t_node'($urandom);
            s.cmd.entry_parent = t_node'($urandom);
        end
        cmd_q.push_back(s);
    endtask

    // a loaded node (or 0 when allow_zero is set), biased towards the newest ones so chains grow deep
    function automatic int pick_node(input bit allow_zero);
        int n;
        int span;
        n = plan_nodes.size();
        if (allow_zero && $urandom_range(0, 11) == 0) return 0;
        span = (n < 8) ? n : 8;
        if ($urandom_range(0, 1) == 0) return plan_nodes[n - 1 - $urandom_range(0, span - 1)];
        return plan_nodes[$urandom_range(0, n - 1)];
    endfunction

    function automatic int climb(input int node);
        int steps;
        int p;
        steps = $urandom_range(0, 40);
        while (steps > 0 && node != 0) begin
            p = 32'(plan_parent[node]);
            if (p == 0 || p >= node) break;
            node = p;
            steps--;
        end
        return node;
    endfunction

    task automatic plan_random_load();
        int roll;
        int w;
        int idx;
        int par;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            w = pick_node(1'b0);
            if (w >= TOP_NODE) begin
                idx = $urandom_range(1, TOP_NODE);
                par = 0;
            end else begin
                idx = w + $urandom_range(1, 2500);
                if (idx > TOP_NODE) idx = $urandom_range(w + 1, TOP_NODE);
                par = w;
            end
        end else if (roll < 88) begin
            idx = $urandom_range(1, TOP_NODE);
            par = 0;
        end else begin
            idx = $urandom_range(1, TOP_NODE);
            par = $urandom_range(idx, TOP_NODE);
        end
        plan_cmd(OP_LOAD, 0, 0, idx, par);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (predict_answer(i_cmd, next_answer)) answer_q.push_back(next_answer);
            end
            if (!start || !busy) begin
                if (cmd_q.size() == 0) begin
                    start <= 1'b0;
                end else if (cmd_q[0].gap > 0) begin
                    cmd_q[0].gap = cmd_q[0].gap - 1;
                    start <= 1'b0;
                end else begin
                    i_cmd <= cmd_q[0].cmd;
                    start <= 1'b1;
                    void'(cmd_q.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid !== 1'b0) begin
            if (answer_q.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing pending, node %0d",
                                        o_res.ancestor_node));
            end else begin
                want = answer_q[0];
                void'(answer_q.pop_front());
                if (o_res.ancestor_node !== want.ancestor_node)
                    flag_mismatch($sformatf("ancestor_node %0d, wanted %0d",
                                            o_res.ancestor_node, want.ancestor_node));
                if (o_res.is_ancestor !== want.is_ancestor)
                    flag_mismatch($sformatf("is_ancestor %b, wanted %b",
                                            o_res.is_ancestor, want.is_ancestor));
                if (o_res.malformed !== want.malformed)
                    flag_mismatch($sformatf("malformed %b, wanted %b",
                                            o_res.malformed, want.malformed));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid === 1'b1) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int counted;
        int roll;
        int a;
        int b;

        // small tree, zero operands and equal nodes
        plan_cmd(OP_LOAD, 0, 0, 1, 0);
        plan_cmd(OP_LOAD, 0, 0, 2, 1);
        plan_cmd(OP_LOAD, 0, 0, 3, 1);
        plan_cmd(OP_LOAD, 0, 0, 4, 2);
        plan_cmd(OP_LCA, 4, 3, 0, 0);
        plan_cmd(OP_LCA, 4, 2, 0, 0);
        plan_cmd(OP_LCA, 0, 3, 0, 0);
        plan_cmd(OP_LCA, 3, 0, 0, 0);
        plan_cmd(OP_LCA, 0, 0, 0, 0);
        plan_cmd(OP_ANC, 2, 4, 0, 0);
        plan_cmd(OP_ANC, 3, 4, 0, 0);
        plan_cmd(OP_ANC, 0, 4, 0, 0);
        plan_cmd(OP_ANC, 4, 4, 0, 0);
        plan_cmd(OP_ANC, 4, 2, 0, 0);
        // second root, so the walk falls off both trees
        plan_cmd(OP_LOAD, 0, 0, 10, 0);
        plan_cmd(OP_LCA, 10, 4, 0, 0);
        // broken parent links
        plan_cmd(OP_LOAD, 0, 0, 20, 20);
        plan_cmd(OP_LCA, 20, 1, 0, 0);
        plan_cmd(OP_LOAD, 0, 0, 21, TOP_NODE);
        plan_cmd(OP_ANC, 1, 21, 0, 0);
        // top of the index range
        plan_cmd(OP_LOAD, 0, 0, 32768, 4);
        plan_cmd(OP_LOAD, 0, 0, TOP_NODE, 32768);
        plan_cmd(OP_LCA, TOP_NODE, 3, 0, 0);
        plan_cmd(OP_ANC, 32768, TOP_NODE, 0, 0);
        plan_cmd(OP_ANC, TOP_NODE, 0, 0, 0);
        plan_cmd(OP_LCA, TOP_NODE, TOP_NODE, 0, 0);
        plan_cmd(OP_SPARE, TOP_NODE, 1, 0, 0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                plan_random_load();
                counted++;
            end else if (roll < 70) begin
                b = pick_node(1'b1);
                a = ($urandom_range(0, 2) == 0) ? climb(b) : pick_node(1'b1);
                plan_cmd(OP_LCA, a, b, 0, 0);
                counted++;
            end else if (roll < 97) begin
                b = pick_node(1'b1);
                a = ($urandom_range(0, 1) == 0) ? climb(b) : pick_node(1'b1);
                plan_cmd(OP_ANC, a, b, 0, 0);
                counted++;
            end else begin
                plan_cmd(OP_SPARE, $urandom_range(0, TOP_NODE), $urandom_range(0, TOP_NODE), 0, 0);
            end
        end

        // bursts of idle cycles, with quiet stretches and none near the end
        for (int i = 0; i < cmd_q.size(); i++) begin
            if (i < cmd_q.size() * 17 / 20 && (i / 40) % 3 != 2 && $urandom_range(0, 3) == 0)
                cmd_q[i].gap = $urandom_range(1, 5);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((cmd_q.size() != 0 || start || answer_q.size() != 0) && idle_cycles < IDLE_LIMIT)
            @(negedge i_clk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_tree_lowest_common_ancestor: errors");
        end else begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            if (fails == 0) begin
                $display("tb_tree_lowest_common_ancestor: clean");
            end else begin
                $display("tb_tree_lowest_common_ancestor: errors");
            end
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/tlca_pkg.sv
sv/tlca_step.sv
sv/tlca_table.sv
sv/tree_lowest_common_ancestor.sv
dv/tb_tree_lowest_common_ancestor.sv
